@@ rtl/tkfv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkfv_pkg: shared types and constants
// Sizes, payload structs and the count table memory interface.
// ----------------------------------------------------------------------------
package tkfv_pkg;

  localparam int TableDepth = 256;
  localparam int KMax       = 64;
  localparam int CountBits  = 16;

  localparam int IdxW  = $clog2(TableDepth);
  localparam int UsedW = $clog2(TableDepth + 1);
  localparam int KIdxW = (KMax > 1) ? $clog2(KMax) : 1;
  localparam int KW    = $clog2(KMax + 1);

  localparam logic [CountBits-1:0] CountLimit = {CountBits{1'b1}};

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [15:0]        occurrences;
    logic               table_overflow;
    logic               last_result;
  } out_item_t;

  // Table access from the controller
  typedef struct packed {
    logic                 rd_en;
    logic [IdxW-1:0]      rd_addr;
    logic                 wr_en;
    logic [IdxW-1:0]      wr_addr;
    logic                 wr_key_en;
    logic [31:0]          wr_key;
    logic [CountBits-1:0] wr_cnt;
  } tbl_req_t;

  typedef struct packed {
    logic [31:0]          key;
    logic [CountBits-1:0] cnt;
  } tbl_rsp_t;

endpackage

@@ rtl/tkfv_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkfv_table: key and count memories
// Synchronous memories, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tkfv_table (
  input  logic              clk_i,
  input  tkfv_pkg::tbl_req_t req_i,
  output tkfv_pkg::tbl_rsp_t rsp_o
);
  import tkfv_pkg::*;

  logic [31:0]          key_mem [TableDepth];
  logic [CountBits-1:0] cnt_mem [TableDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      cnt_mem[req_i.wr_addr] <= req_i.wr_cnt;
      if (req_i.wr_key_en) begin
        key_mem[req_i.wr_addr] <= req_i.wr_key;
      end
    end
    if (req_i.rd_en) begin
      rsp_o.key <= key_mem[req_i.rd_addr];
      rsp_o.cnt <= cnt_mem[req_i.rd_addr];
    end
  end

endmodule

@@ rtl/top_k_frequent_values.sv @@
`timescale 1ns / 1ps
// Sequence: an item holds the block while it is compared with each table entry
//   in turn (a compare state even on an empty table), then the update state;
//   a last item then streams the table through the selection pass, then gives
//   one result per cycle while out_ready_i is high.
// Flow: one item at a time; no new item is taken until the last one is done.
// Reset: clears control state, fill count, overflow and k (to 1); memories are not cleared.
// ----------------------------------------------------------------------------
// top_k_frequent_values: top-k frequent value counter
// Counts distinct values in a memory table and reports the k most frequent.
// ----------------------------------------------------------------------------
module top_k_frequent_values (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tkfv_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tkfv_pkg::out_item_t  out_data_o
);
  import tkfv_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSearch = 3'd1;  // read issued, compare next
  localparam logic [2:0] StSelect = 3'd2;  // stream table into sorted list
  localparam logic [2:0] StEmit   = 3'd3;
  localparam logic [2:0] StUpdate = 3'd4;  // write has landed after hit/miss

  logic [2:0]           state_q, state_d;
  logic [6:0]           k_reg_q;
  logic [31:0]          key_q;
  logic                 last_q;
  logic [UsedW-1:0]     used_q, used_d;
  logic [UsedW-1:0]     ptr_q, ptr_d;     // address of outstanding read
  logic                 ovf_q, ovf_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [KW-1:0]        k_eff;
  logic [KW-1:0]        best_used_q, best_used_d;
  logic [KIdxW-1:0]     emit_q, emit_d;
  logic [31:0]          bkey_q [KMax];
  logic [CountBits-1:0] bcnt_q [KMax];
  logic                 ins_en;
  logic                 emit_adv;
  logic [31:0]          ins_key;
  logic [CountBits-1:0] ins_cnt;
  tbl_req_t             req;
  tbl_rsp_t             rsp;
  logic                 out_valid_q, out_valid_d;

  tkfv_table u_table (.clk_i(clk_i), .req_i(req), .rsp_o(rsp));

  // effective k: zero means one, saturate at KMax
  always_comb begin
    if (k_reg_q == 7'd0) begin
      k_eff = KW'(1);
    end else if (32'(k_reg_q) > KMax) begin
      k_eff = KW'(KMax);
    end else begin
      k_eff = KW'(k_reg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_reg_q <= 7'd1;
    end else if (cfg_we_i) begin
      k_reg_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  // advance the sorted list by one slot on every accepted result
  assign emit_adv = (state_q == StEmit) && out_ready_i;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    ptr_d       = ptr_q;
    ovf_d       = ovf_q;
    rd_pend_d   = 1'b0;
    best_used_d = best_used_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q;
    ins_en      = 1'b0;
    ins_key     = rsp.key;
    ins_cnt     = rsp.cnt;
    req         = '0;
    req.wr_key  = key_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ptr_d = '0;
          if (used_q != '0) begin
            req.rd_en = 1'b1;
            req.rd_addr = '0;
            rd_pend_d = 1'b1;
          end
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (rd_pend_q && rsp.key == key_q) begin
          // hit: bump the count, saturating
          req.wr_en   = 1'b1;
          req.wr_addr = ptr_q[IdxW-1:0];
          req.wr_cnt  = (rsp.cnt == CountLimit) ? rsp.cnt : rsp.cnt + 1'b1;
          state_d     = StUpdate;
        end else if (rd_pend_q && ptr_q + 1'b1 < used_q) begin
          ptr_d       = ptr_q + 1'b1;
          req.rd_en   = 1'b1;
          req.rd_addr = IdxW'(ptr_q + 1'b1);
          rd_pend_d   = 1'b1;
        end else begin
          // miss: append or drop
          if (32'(used_q) < TableDepth) begin
            req.wr_en     = 1'b1;
            req.wr_key_en = 1'b1;
            req.wr_addr   = IdxW'(used_q);
            req.wr_cnt    = CountBits'(1);
            used_d        = used_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        // write has landed; start selection or finish
        if (last_q) begin
          best_used_d = '0;
          ptr_d       = '0;
          req.rd_en   = 1'b1;
          req.rd_addr = '0;
          rd_pend_d   = 1'b1;
          state_d     = StSelect;
        end else begin
          state_d = StIdle;
        end
      end
      StSelect: begin
        if (ptr_q < used_q) begin
          ins_en = 1'b1;
          if (best_used_q < k_eff) begin
            best_used_d = best_used_q + 1'b1;
          end
          ptr_d       = ptr_q + 1'b1;
          req.rd_en   = 1'b1;
          req.rd_addr = IdxW'(ptr_q + 1'b1);
          rd_pend_d   = 1'b1;
        end else begin
          emit_d      = '0;
          out_valid_d = (best_used_q != '0);
          state_d     = (best_used_q != '0) ? StEmit : StIdle;
          used_d      = '0;
          if (best_used_q == '0) begin
            ovf_d = 1'b0;
          end
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          if (KW'(emit_q) + 1'b1 == best_used_q) begin
            out_valid_d = 1'b0;
            ovf_d       = 1'b0;
            state_d     = StIdle;
          end else begin
            emit_d = emit_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      ptr_q       <= '0;
      ovf_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      best_used_q <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      ptr_q       <= ptr_d;
      ovf_q       <= ovf_d;
      rd_pend_q   <= rd_pend_d;
      best_used_q <= best_used_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      key_q  <= in_data_i.value;
      last_q <= in_data_i.last_item;
    end
  end

  // Sorted list: each slot takes the new pair, its upper neighbor or holds.
  // A slot moves down when the new count beats it; strict compare keeps ties
  // in first-seen order. While emitting, shift every slot but the last toward slot zero.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < KMax; j++) begin
      if (ins_en && KW'(j) < k_eff) begin
        if (KW'(j) >= best_used_q || bcnt_q[j] < ins_cnt) begin
          if (j > 0 && KW'(j) < best_used_q + 1'b1 && KW'(j - 1) < best_used_q
              && bcnt_q[(j > 0) ? j - 1 : 0] < ins_cnt) begin
            bkey_q[j] <= bkey_q[(j > 0) ? j - 1 : 0];
            bcnt_q[j] <= bcnt_q[(j > 0) ? j - 1 : 0];
          end else if (KW'(j) <= best_used_q) begin
            bkey_q[j] <= ins_key;
            bcnt_q[j] <= ins_cnt;
          end
        end
      end else if (emit_adv && j < KMax - 1) begin
        bkey_q[j] <= bkey_q[(j < KMax - 1) ? j + 1 : j];
        bcnt_q[j] <= bcnt_q[(j < KMax - 1) ? j + 1 : j];
      end
    end
  end

  always_comb begin
    out_data_o.top_value      = bkey_q[0];
    out_data_o.occurrences    = (CountBits > 16 && 32'(bcnt_q[0]) > 32'hFFFF)
                                ? 16'hFFFF : 16'(bcnt_q[0]);
    out_data_o.table_overflow = ovf_q;
    out_data_o.last_result    = (KW'(emit_q) + 1'b1 == best_used_q);
  end
  assign out_valid_o = out_valid_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= TableDepth) else $error("fill count beyond table depth");
  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_used_q <= k_eff || state_q != StSelect) else $error("list over k");
  a_out_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StEmit) else $error("result outside emit");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o) else $error("accept while busy");

endmodule

@@ tb/top_k_frequent_values_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_frequent_values_tb: self-checking bench for the top-k value counter
// Streams sets of values, predicts the sorted top-k list of each set, and
// checks every result item field by field under random handshake idling.
// ----------------------------------------------------------------------------
module top_k_frequent_values_tb;
  import tkfv_pkg::*;

  localparam int LimitCycles = 1500000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  top_k_frequent_values i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Shadow of the block: value table in first-seen order plus the k register
  logic [31:0]          seen_keys[$];
  logic [CountBits-1:0] seen_counts[$];
  logic                 seen_overflow = 1'b0;
  logic [6:0]           k_reg = 7'd1;
  out_item_t            pending_results[$];

  int  errors = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  sets_done = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;

  // Count one value, then on the last item rank the table and queue results
  task automatic count_value(input in_item_t it);
    int            hit;
    int            k;
    int            pos;
    logic [31:0]   rank_key[$];
    logic [15:0]   rank_cnt[$];
    out_item_t     res;
    hit = -1;
    foreach (seen_keys[i]) if (seen_keys[i] == it.value) hit = i;
    if (hit >= 0) begin
      if (seen_counts[hit] != CountLimit) seen_counts[hit]++;
    end else if (seen_keys.size() < TableDepth) begin
      seen_keys.insert(seen_keys.size(), it.value);
      seen_counts.insert(seen_counts.size(), CountBits'(1));
    end else begin
      seen_overflow = 1'b1;
    end
    if (!it.last_item) return;
    k = (k_reg == 0) ? 1 : ((k_reg > KMax) ? KMax : k_reg);
    // Stable insertion: an entry passes only strictly smaller counts
    foreach (seen_keys[i]) begin
      pos = rank_key.size();
      while (pos > 0 && rank_cnt[pos-1] < seen_counts[i]) pos--;
      if (pos < k) begin
        rank_key.insert(pos, seen_keys[i]);
        rank_cnt.insert(pos, seen_counts[i]);
        if (rank_key.size() > k) begin
          void'(rank_key.pop_back());
          void'(rank_cnt.pop_back());
        end
      end
    end
    foreach (rank_key[i]) begin
      res.top_value      = rank_key[i];
      res.occurrences    = rank_cnt[i];
      res.table_overflow = seen_overflow;
      res.last_result    = (i == rank_key.size() - 1);
      pending_results.insert(pending_results.size(), res);
    end
    seen_keys.delete();
    seen_counts.delete();
    seen_overflow = 1'b0;
    sets_done++;
  endtask

  task automatic push_item(input logic [31:0] v, input logic lst);
    in_item_t it;
    it.value = v;
    it.last_item = lst;
    // step off the edge that dropped valid for the previous item
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    count_value(it);
    items_sent++;
    in_valid_i <= 1'b0;
  endtask

  // Write k only once the block has drained every result and settled
  task automatic write_k(input logic [6:0] k);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    k_reg = k;
  endtask

  // Receiver: random stall, check each accepted result against the queue
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          $error("unexpected result value=%0d", out_data_o.top_value);
          errors++;
        end else begin
          out_item_t exp_res;
          exp_res = pending_results.pop_front();
          if (out_data_o.top_value !== exp_res.top_value) begin
            $error("top_value exp %0d got %0d", exp_res.top_value,
                   out_data_o.top_value);
            errors++;
          end
          if (out_data_o.occurrences !== exp_res.occurrences) begin
            $error("occurrences exp %0d got %0d", exp_res.occurrences,
                   out_data_o.occurrences);
            errors++;
          end
          if (out_data_o.table_overflow !== exp_res.table_overflow) begin
            $error("table_overflow exp %0b got %0b", exp_res.table_overflow,
                   out_data_o.table_overflow);
            errors++;
          end
          if (out_data_o.last_result !== exp_res.last_result) begin
            $error("last_result exp %0b got %0b", exp_res.last_result,
                   out_data_o.last_result);
            errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard stop on a hung handshake
  always @(posedge clk_i) begin
    if (cycles >= LimitCycles) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Directed sets: value, last flag, and where obvious the single expected
  // result under the reset value of k (value and count).
  typedef struct {
    logic [31:0] v;
    logic        lst;
    logic        chk;
    logic [31:0] ev;
    logic [15:0] ec;
  } stim_row_t;

  stim_row_t directed_rows[10] = '{
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 16'd0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 16'd0},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 16'd2},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 16'd1},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 16'd0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0, 16'd0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 16'd0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0, 16'd0},
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0, 16'd0},
    '{32'h0000_0005, 1'b1, 1'b1, 32'h0000_0005, 16'd3}
  };

  // One random set: mostly a few repeated values, sometimes wide noise
  task automatic random_set(input int len, input int span);
    logic [31:0] v;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) v = $urandom();
      else v = $urandom_range(span) - span / 2;
      push_item(v, i == len - 1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of k: each set reports only its top value
    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].v, directed_rows[i].lst);
      if (directed_rows[i].chk) begin
        if (pending_results[pending_results.size() - 1].top_value
            !== directed_rows[i].ev) begin
          $error("top_value exp %0d got %0d", directed_rows[i].ev,
                 pending_results[pending_results.size() - 1].top_value);
          errors++;
        end
        if (pending_results[pending_results.size() - 1].occurrences
            !== directed_rows[i].ec) begin
          $error("occurrences exp %0d got %0d", directed_rows[i].ec,
                 pending_results[pending_results.size() - 1].occurrences);
          errors++;
        end
      end
    end
    write_k(7'd0);       // zero acts as one
    push_item(32'd9, 1'b0);
    push_item(32'd8, 1'b1);
    write_k(7'd127);     // above the list size, clamps to 64
    push_item(32'd1, 1'b0);
    push_item(32'd2, 1'b0);
    push_item(32'd2, 1'b1);

    // Random sets under three idling profiles and several k values
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 67 : 0;
      recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 22 : 0;
      write_k(phase == 0 ? 7'd3 : phase == 1 ? 7'd1 : 7'd64);
      for (int s = 0; s < 6; s++) random_set($urandom_range(10, 1), $urandom_range(12, 2));
      // Sender pauses until the block has drained
      while (pending_results.size() != 0) @(posedge clk_i);
      write_k(7'($urandom_range(64, 1)));
      for (int s = 0; s < 3; s++) random_set($urandom_range(10, 1), 40);
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    $display("Sent %0d items in %0d sets, checked %0d results",
             items_sent, sets_done, results_seen);
    $display("Covered k of 0, 1, 3, 64, 127, extreme values and three idling profiles");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tkfv_pkg.sv
rtl/tkfv_table.sv
rtl/top_k_frequent_values.sv
tb/top_k_frequent_values_tb.sv
